[src/learning_switch_forwarder_top_defines.svh]
// ----------------------------------------------------------------------------
// learning switch forwarder assertion macros
// concurrent checks that compile away when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef LEARNING_SWITCH_FORWARDER_TOP_DEFINES_SVH
`define LEARNING_SWITCH_FORWARDER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define LSF_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lsf check failed: ante |-> cons");
`define LSF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lsf check failed: ante |=> cons");
`else
`define LSF_ASSERT_IMPLY(lbl, ante, cons)
`define LSF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[src/lsf_pkg.sv]
// ----------------------------------------------------------------------------
// lsf_pkg
// request and result types, command codes and sequencer states
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lsf_pkg;

  localparam int MAX_RESULTS = 8;
  localparam int FIELD_ID_W  = 8;

  typedef enum logic [2:0] {
    CMD_CONNECT_SYSTEM = 3'd0,
    CMD_CONNECT_SWITCH = 3'd1,
    CMD_FRAME_SYSTEM   = 3'd2,
    CMD_FRAME_SWITCH   = 3'd3,
    CMD_ENABLE         = 3'd4
  } command_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } state_t;

  localparam logic [0:0] REG_OWN_SWITCH_ID = 1'b0;

  typedef struct packed {
    logic [2:0]            command;
    logic [3:0]            port_number;
    logic [FIELD_ID_W-1:0] node_id;
    logic [FIELD_ID_W-1:0] dest_id;
    logic [15:0]           payload_tag;
  } request_t;

  typedef struct packed {
    logic [2:0]            out_port;
    logic                  to_switch;
    logic [FIELD_ID_W-1:0] frame_dest;
    logic [15:0]           frame_tag;
    logic [FIELD_ID_W-1:0] sender_switch;
    logic                  last;
  } result_t;

endpackage

[src/lsf_pick.sv]
// ----------------------------------------------------------------------------
// lsf_pick
// picks the lowest pending flood port and returns the mask without it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsf_pick #(
  parameter int PORTS = 8
) (
  input  logic [PORTS-1:0]                          mask,
  output logic [(PORTS > 1 ? $clog2(PORTS) : 1)-1:0] idx,
  output logic [PORTS-1:0]                          rest
);

  localparam int PW = (PORTS > 1) ? $clog2(PORTS) : 1;

  logic [PORTS-1:0] low;

  assign low  = mask & (~mask + {{(PORTS-1){1'b0}}, 1'b1});
  assign rest = mask & ~low;

  // one-hot to binary
  always_comb begin
    idx = '0;
    for (int i = 0; i < PORTS; i++) begin
      if (low[i]) begin
        idx = idx | PW'(i);
      end
    end
  end

endmodule

[src/learning_switch_forwarder_top.sv]
// ----------------------------------------------------------------------------
// learning_switch_forwarder_top
// port table with learning, unicast lookup and flooding to connected peers
// ----------------------------------------------------------------------------
//  channel   signals                                   handshake
//  request   start, busy, request                      start && !busy
//  result    result_strobe, result                     one cycle, no stall
//  config    psel, penable, pwrite, paddr, pwdata,     psel && penable &&
//            prdata, pready                            pwrite, pready high
//
// connect and unknown commands are handled in idle, with no scan. frames and
// enables scan the peer and learned memories one port a cycle, then a frame
// gives one result a cycle: one for unicast, up to 8 for a flood.
// reset clears the per-port flags and the switch id, no clearing pass.
// busy is high from the scan until the last result is issued.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "learning_switch_forwarder_top_defines.svh"

module learning_switch_forwarder_top #(
  parameter int PORTS   = 8,
  parameter int ID_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  lsf_pkg::request_t request,
  output logic              result_strobe,
  output lsf_pkg::result_t  result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  import lsf_pkg::*;

  localparam int PW = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int CW = $clog2(PORTS + 1);
  localparam int EW = $clog2(MAX_RESULTS);

  state_t state, state_next;

  logic [FIELD_ID_W-1:0] own_switch_id;

  logic [PORTS-1:0] peer_valid;
  logic [PORTS-1:0] peer_is_switch;
  logic [PORTS-1:0] learned_valid;
  logic [PORTS-1:0] port_enabled;

  logic [ID_BITS-1:0] peer_mem    [PORTS];
  logic [ID_BITS-1:0] learned_mem [PORTS];
  logic [ID_BITS-1:0] peer_rd;
  logic [ID_BITS-1:0] learned_rd;

  request_t         req_q;
  logic [CW-1:0]    cnt;
  logic             learn_done;
  logic             uni_found;
  logic [PW-1:0]    uni_idx;
  logic [PORTS-1:0] flood_mask;
  logic [EW-1:0]    emit_cnt;

  logic               accept;
  logic               is_connect;
  logic               port_ok;
  logic [PW-1:0]      conn_addr;
  logic [ID_BITS-1:0] node_key;
  logic [ID_BITS-1:0] dest_key;
  logic               from_switch;
  logic               is_enable;
  logic [PW-1:0]      raddr;
  logic [PW-1:0]      eidx;
  logic               scan_eval;
  logic               scan_end;
  logic               pv, ps, lv, en;
  logic               node_match;
  logic               learn_hit;
  logic               uni_hit;
  logic               flood_bit;
  logic               en_set;
  logic               cfg_write;

  logic [PW-1:0]    pick_idx;
  logic [PORTS-1:0] pick_rest;

  logic          emit_fire;
  logic [PW-1:0] emit_idx;
  logic          emit_sw;
  logic          emit_last;

  assign pready    = 1'b1;
  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_write = psel && penable && pwrite && pready;

  assign is_connect = (request.command == CMD_CONNECT_SYSTEM) ||
                      (request.command == CMD_CONNECT_SWITCH);
  assign port_ok    = (request.port_number != 4'd0) &&
                      (32'(request.port_number) <= PORTS);
  assign conn_addr  = PW'(request.port_number - 4'd1);

  assign node_key    = ID_BITS'(req_q.node_id);
  assign dest_key    = ID_BITS'(req_q.dest_id);
  assign from_switch = (req_q.command == CMD_FRAME_SWITCH);
  assign is_enable   = (req_q.command == CMD_ENABLE);

  // read address is one entry ahead of the evaluated entry, as the read is registered
  assign raddr     = PW'(cnt);
  assign eidx      = PW'(cnt - CW'(1));
  assign scan_eval = (state == S_SCAN) && (cnt != '0);
  assign scan_end  = (state == S_SCAN) && (cnt == CW'(PORTS));

  assign pv = peer_valid[eidx];
  assign ps = peer_is_switch[eidx];
  assign lv = learned_valid[eidx];
  assign en = port_enabled[eidx];

  assign node_match = (peer_rd == node_key);
  assign learn_hit  = scan_eval && !is_enable && !learn_done && pv && node_match &&
                      (ps == from_switch);
  // a learn at this entry is seen by the unicast check at once
  assign uni_hit    = scan_eval && !is_enable && !uni_found && !ps &&
                      (learn_hit ? (node_key == dest_key)
                                 : (lv && (learned_rd == dest_key)));
  assign flood_bit  = pv && (ps ? (en && !(from_switch && node_match)) : 1'b1);
  assign en_set     = scan_eval && is_enable && pv && ps && node_match;

  lsf_pick #(
    .PORTS(PORTS)
  ) u_pick (
    .mask(flood_mask),
    .idx (pick_idx),
    .rest(pick_rest)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && ((request.command == CMD_FRAME_SYSTEM) ||
                       (request.command == CMD_FRAME_SWITCH) ||
                       (request.command == CMD_ENABLE))) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_next = is_enable ? S_IDLE : S_EMIT;
        end
      end
      S_EMIT: begin
        if (uni_found || (flood_mask == '0) || emit_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    emit_fire = 1'b0;
    emit_idx  = pick_idx;
    emit_sw   = 1'b0;
    emit_last = 1'b0;
    if (state == S_EMIT) begin
      priority if (uni_found) begin
        emit_fire = 1'b1;
        emit_idx  = uni_idx;
        emit_last = 1'b1;
      end else if (flood_mask != '0) begin
        emit_fire = 1'b1;
        emit_sw   = peer_is_switch[pick_idx];
        emit_last = (pick_rest == '0) || (emit_cnt == EW'(MAX_RESULTS - 1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt < CW'(PORTS)) begin
      peer_rd    <= peer_mem[raddr];
      learned_rd <= learned_mem[raddr];
    end
    if (accept && is_connect && port_ok) begin
      peer_mem[conn_addr] <= ID_BITS'(request.node_id);
    end
    if (learn_hit) begin
      learned_mem[eidx] <= node_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peer_valid     <= '0;
      peer_is_switch <= '0;
      learned_valid  <= '0;
      port_enabled   <= '0;
      own_switch_id  <= '0;
    end else begin
      if (cfg_write && (paddr[2] == REG_OWN_SWITCH_ID)) begin
        own_switch_id <= pwdata[FIELD_ID_W-1:0];
      end
      if (accept && is_connect && port_ok) begin
        peer_valid[conn_addr]     <= 1'b1;
        peer_is_switch[conn_addr] <= (request.command == CMD_CONNECT_SWITCH);
      end
      if (learn_hit) begin
        learned_valid[eidx] <= 1'b1;
      end
      if (en_set) begin
        port_enabled[eidx] <= 1'b1;
      end
      // flood path clears every enable
      if (scan_end && !is_enable && !uni_found && !uni_hit) begin
        port_enabled <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      learn_done <= 1'b0;
      uni_found  <= 1'b0;
      emit_cnt   <= '0;
      flood_mask <= '0;
    end else begin
      if (accept) begin
        cnt        <= '0;
        learn_done <= 1'b0;
        uni_found  <= 1'b0;
        emit_cnt   <= '0;
        flood_mask <= '0;
      end else if (state == S_SCAN) begin
        cnt <= cnt + CW'(1);
        if (learn_hit) begin
          learn_done <= 1'b1;
        end
        if (uni_hit) begin
          uni_found <= 1'b1;
        end
        if (scan_eval && !is_enable) begin
          flood_mask[eidx] <= flood_bit;
        end
      end else if (emit_fire && !uni_found) begin
        flood_mask <= pick_rest;
        emit_cnt   <= emit_cnt + EW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= request;
    end
    if (uni_hit) begin
      uni_idx <= eidx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= emit_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      result.out_port      <= 3'(emit_idx);
      result.to_switch     <= emit_sw;
      result.frame_dest    <= req_q.dest_id;
      result.frame_tag     <= req_q.payload_tag;
      result.sender_switch <= emit_sw ? own_switch_id : '0;
      result.last          <= emit_last;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_OWN_SWITCH_ID) begin
      prdata = 32'(own_switch_id);
    end
  end

  `LSF_ASSERT_IMPLY(a_strobe_after_emit, result_strobe, $past(state) == S_EMIT)
  `LSF_ASSERT_NEXT(a_unicast_single_last, (state == S_EMIT) && uni_found, result_strobe && result.last && (state == S_IDLE))
  `LSF_ASSERT_IMPLY(a_flood_enables_cleared, (state == S_EMIT) && !uni_found, port_enabled == '0)
  `LSF_ASSERT_IMPLY(a_busy_while_scanning, (state == S_SCAN) && (cnt != '0), busy && !emit_fire)

endmodule

[bench/learning_switch_forwarder_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// learning_switch_forwarder_top_tb
// sends connect, enable and frame requests through the command port and
// checks every forwarded result against a port table model kept in the bench;
// the switch id register is rewritten and read back between phases
// ----------------------------------------------------------------------------
module learning_switch_forwarder_top_tb;
  import lsf_pkg::*;

  localparam int         PORTS              = 8;
  localparam int         SETTLE_CYCLES      = PORTS + 1 + MAX_RESULTS + 6;
  localparam int         MAX_REPORTS        = 10;
  localparam logic [2:0] CMD_RESERVED_FIRST = 3'd5;
  localparam logic [2:0] CMD_RESERVED_LAST  = 3'd7;
  localparam logic [2:0] OWN_ID_ADDR        = {REG_OWN_SWITCH_ID, 2'b00};

  logic        clk     = 1'b0;
  logic        rst     = 1'b1;
  logic        start   = 1'b0;
  logic        busy;
  request_t    request = '0;
  logic        result_strobe;
  result_t     result;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  // port table as the bench sees it
  bit       tbl_connected  [PORTS];
  bit [7:0] tbl_peer       [PORTS];
  bit       tbl_is_switch  [PORTS];
  bit       tbl_learned    [PORTS];
  bit [7:0] tbl_learned_id [PORTS];
  bit       tbl_enabled    [PORTS];
  bit [7:0] own_id;

  result_t  pending_results[$];
  bit [7:0] id_pool[6];
  int       mismatches;
  int       results_seen;
  int       frames_sent;
  int       unicasts;
  int       floods;
  int       id_settings;

  learning_switch_forwarder_top #(
    .PORTS  (PORTS),
    .ID_BITS(8)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .result_strobe(result_strobe),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk = ~clk;

  function automatic string describe_result(input result_t r);
    return $sformatf("port %0d sw %0b dest %h tag %h sender %h last %0b",
                     r.out_port, r.to_switch, r.frame_dest, r.frame_tag,
                     r.sender_switch, r.last);
  endfunction

  function automatic result_t make_result(input int port, input bit sw,
                                          input request_t r);
    result_t res;
    res.out_port      = 3'(port);
    res.to_switch     = sw;
    res.frame_dest    = r.dest_id;
    res.frame_tag     = r.payload_tag;
    res.sender_switch = sw ? own_id : 8'h00;
    res.last          = 1'b0;
    return res;
  endfunction

  task automatic queue_expected(input result_t r);
    pending_results = {pending_results, r};
  endtask

  task automatic forward_model(input request_t r);
    int      hit;
    bit      from_sw;
    bit      learned_now;
    result_t uni_res;
    result_t flood_q[$];
    hit         = -1;
    learned_now = 1'b0;
    from_sw     = (r.command == CMD_FRAME_SWITCH);
    case (r.command)
      CMD_CONNECT_SYSTEM, CMD_CONNECT_SWITCH: begin
        if (r.port_number >= 1 && r.port_number <= PORTS) begin
          tbl_connected[r.port_number - 1] = 1'b1;
          tbl_peer[r.port_number - 1]      = r.node_id;
          tbl_is_switch[r.port_number - 1] = (r.command == CMD_CONNECT_SWITCH);
        end
      end
      CMD_ENABLE: begin
        for (int i = 0; i < PORTS; i++)
          if (tbl_connected[i] && tbl_is_switch[i] && tbl_peer[i] == r.node_id)
            tbl_enabled[i] = 1'b1;
      end
      CMD_FRAME_SYSTEM, CMD_FRAME_SWITCH: begin
        frames_sent++;
        for (int i = 0; i < PORTS; i++) begin
          if (!learned_now && tbl_connected[i] && tbl_peer[i] == r.node_id &&
              tbl_is_switch[i] == from_sw) begin
            tbl_learned[i]    = 1'b1;
            tbl_learned_id[i] = r.node_id;
            learned_now       = 1'b1;
          end
        end
        for (int i = PORTS - 1; i >= 0; i--)
          if (tbl_learned[i] && tbl_learned_id[i] == r.dest_id && !tbl_is_switch[i])
            hit = i;
        if (hit >= 0) begin
          unicasts++;
          uni_res      = make_result(hit, 1'b0, r);
          uni_res.last = 1'b1;
          queue_expected(uni_res);
        end else begin
          floods++;
          for (int i = 0; i < PORTS && flood_q.size() < MAX_RESULTS; i++) begin
            if (!tbl_connected[i]) continue;
            if (!tbl_is_switch[i])
              flood_q = {flood_q, make_result(i, 1'b0, r)};
            else if (tbl_enabled[i] && !(from_sw && tbl_peer[i] == r.node_id))
              flood_q = {flood_q, make_result(i, 1'b1, r)};
          end
          if (flood_q.size() > 0) flood_q[$].last = 1'b1;
          foreach (flood_q[k]) queue_expected(flood_q[k]);
          for (int i = 0; i < PORTS; i++) tbl_enabled[i] = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_strobe) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: %s", describe_result(result));
      end else begin
        want = pending_results.pop_front();
        if (result.out_port !== want.out_port || result.to_switch !== want.to_switch ||
            result.frame_dest !== want.frame_dest || result.frame_tag !== want.frame_tag ||
            result.sender_switch !== want.sender_switch || result.last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result mismatch: expected %s, got %s",
                     describe_result(want), describe_result(result));
        end
      end
    end
  end

  task automatic send_request(input request_t r);
    start   <= 1'b1;
    request <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    forward_model(r);
  endtask

  task automatic send_cmd(input logic [2:0] cmd, input logic [3:0] port,
                          input logic [7:0] node, input logic [7:0] dest,
                          input logic [15:0] tag);
    request_t r;
    r.command     = cmd;
    r.port_number = port;
    r.node_id     = node;
    r.dest_id     = dest;
    r.payload_tag = tag;
    send_request(r);
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // hold off until every pending result is in and the scan has surely finished
  task automatic drain_results();
    idle_cycles(1);
    while (pending_results.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_own_id(input logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= OWN_ID_ADDR;
    pwdata  <= {24'($urandom), v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    own_id = v;
    id_settings++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {24'h0, v}) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("switch id readback: expected %h, got %h", v, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [7:0] pick_id();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return id_pool[$urandom_range($size(id_pool) - 1)];
    if (roll < 80) return ($urandom_range(1) == 0) ? 8'h00 : 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  function automatic request_t random_request();
    request_t r;
    int       roll;
    roll          = $urandom_range(99);
    r.node_id     = pick_id();
    r.dest_id     = pick_id();
    r.payload_tag = 16'($urandom);
    r.port_number = 4'($urandom_range(PORTS, 1));
    if (roll < 12) r.command = CMD_CONNECT_SYSTEM;
    else if (roll < 24) r.command = CMD_CONNECT_SWITCH;
    else if (roll < 36) r.command = CMD_ENABLE;
    else if (roll < 62) r.command = CMD_FRAME_SYSTEM;
    else if (roll < 90) r.command = CMD_FRAME_SWITCH;
    else if (roll < 95) begin
      r.command     = ($urandom_range(1) == 0) ? CMD_CONNECT_SYSTEM : CMD_CONNECT_SWITCH;
      r.port_number = ($urandom_range(1) == 0) ? 4'd0 : 4'($urandom_range(15, PORTS + 1));
    end else begin
      r.command     = 3'($urandom_range(CMD_RESERVED_LAST, CMD_RESERVED_FIRST));
      r.port_number = 4'($urandom_range(15));
    end
    return r;
  endfunction

  task automatic run_traffic(input int items, input bit steady);
    int sent;
    int burst;
    sent = 0;
    foreach (id_pool[k]) id_pool[k] = 8'($urandom_range(255));
    while (sent < items) begin
      burst = steady ? items : $urandom_range(12, 1);
      for (int k = 0; k < burst && sent < items; k++) begin
        send_request(random_request());
        sent++;
      end
      if ($urandom_range(15) == 0) drain_results();
      else idle_cycles($urandom_range(8, 1));
    end
  endtask

  task automatic test_empty_table();
    send_cmd(CMD_FRAME_SYSTEM, 4'd1, 8'h00, 8'hFF, 16'h0000);
    send_cmd(CMD_FRAME_SWITCH, 4'd15, 8'hFF, 8'h00, 16'hFFFF);
  endtask

  task automatic test_connect_commands();
    send_cmd(CMD_CONNECT_SYSTEM, 4'd1, 8'h00, 8'h00, 16'($urandom));
    send_cmd(CMD_CONNECT_SYSTEM, 4'(PORTS), 8'hFF, 8'hFF, 16'($urandom));
    send_cmd(CMD_CONNECT_SWITCH, 4'd2, 8'h55, 8'h00, 16'($urandom));
    send_cmd(CMD_CONNECT_SWITCH, 4'd3, 8'hAA, 8'h00, 16'($urandom));
    // out of range ports are dropped
    send_cmd(CMD_CONNECT_SYSTEM, 4'd0, 8'h11, 8'h00, 16'($urandom));
    send_cmd(CMD_CONNECT_SWITCH, 4'(PORTS + 1), 8'h22, 8'h00, 16'($urandom));
    send_cmd(CMD_CONNECT_SYSTEM, 4'd15, 8'h33, 8'h00, 16'($urandom));
    send_cmd(CMD_RESERVED_FIRST, 4'd4, 8'h55, 8'h55, 16'($urandom));
    send_cmd(CMD_RESERVED_FIRST + 3'd1, 4'd5, 8'h00, 8'hFF, 16'($urandom));
    send_cmd(CMD_RESERVED_LAST, 4'd8, 8'hFF, 8'h00, 16'($urandom));
  endtask

  task automatic test_flooding();
    send_cmd(CMD_ENABLE, 4'd0, 8'h55, 8'h00, 16'($urandom));
    send_cmd(CMD_ENABLE, 4'd0, 8'h77, 8'h00, 16'($urandom));
    // source switch is skipped in the flood
    send_cmd(CMD_FRAME_SWITCH, 4'd0, 8'h55, 8'h42, 16'($urandom));
    send_cmd(CMD_ENABLE, 4'd0, 8'h55, 8'h00, 16'($urandom));
    send_cmd(CMD_ENABLE, 4'd0, 8'hAA, 8'h00, 16'($urandom));
    send_cmd(CMD_FRAME_SYSTEM, 4'd0, 8'h99, 8'h42, 16'($urandom));
  endtask

  task automatic test_learning_and_unicast();
    send_cmd(CMD_FRAME_SYSTEM, 4'd0, 8'h00, 8'h12, 16'($urandom));
    send_cmd(CMD_FRAME_SYSTEM, 4'd0, 8'hFF, 8'h00, 16'($urandom));
    send_cmd(CMD_FRAME_SWITCH, 4'd0, 8'hAA, 8'hFF, 16'($urandom));
    // an id learned on a switch port never gets unicast
    send_cmd(CMD_FRAME_SYSTEM, 4'd0, 8'h00, 8'hAA, 16'($urandom));
    // reconnect keeps the learned entry but the port is now a switch
    send_cmd(CMD_CONNECT_SWITCH, 4'd1, 8'h00, 8'h00, 16'($urandom));
    send_cmd(CMD_FRAME_SYSTEM, 4'd0, 8'hFF, 8'h00, 16'($urandom));
  endtask

  task automatic test_switch_id_register();
    drain_results();
    write_own_id(8'hFF);
    send_cmd(CMD_ENABLE, 4'd0, 8'h00, 8'h00, 16'($urandom));
    send_cmd(CMD_ENABLE, 4'd0, 8'hAA, 8'h00, 16'($urandom));
    send_cmd(CMD_FRAME_SYSTEM, 4'd0, 8'h42, 8'h42, 16'($urandom));
  endtask

  task automatic test_random_traffic();
    drain_results();
    write_own_id(8'($urandom_range(255)));
    run_traffic(120, 1'b0);
    drain_results();
    write_own_id(8'hAA);
    run_traffic(110, 1'b1);
    drain_results();
    write_own_id(8'h00);
    run_traffic(120, 1'b0);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_connect_commands();
    test_flooding();
    test_learning_and_unicast();
    test_switch_id_register();
    test_random_traffic();
    drain_results();
    $display("covered %0d frames: %0d unicast, %0d flooded; %0d results checked",
             frames_sent, unicasts, floods, results_seen);
    $display("switch id written %0d times, %0d mismatches", id_settings, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[learning_switch_forwarder_top] OK");
    end else begin
      $display("[learning_switch_forwarder_top] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results pending", pending_results.size());
    $display("[learning_switch_forwarder_top] ERROR");
    $finish;
  end

endmodule

[learning_switch_forwarder_top.f]
+incdir+src
src/lsf_pkg.sv
src/lsf_pick.sv
src/learning_switch_forwarder_top.sv
bench/learning_switch_forwarder_top_tb.sv
